// ===== hw/rtl/sas_pkg.sv =====
// ----------------------------------------------------------------------------
// sas_pkg: shared types and codes for the strategy automaton stepper
// Operation and result codes, field widths, and the structs that carry
// table writes, table read addresses and capped configuration between modules.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int VEC_W   = 56;
  localparam int ID_W    = 8;
  localparam int CNT_W   = 5;
  localparam int SLOT_W  = 4;
  localparam int SENS_W  = 16;
  localparam int CFGD_W  = 5;
  localparam int CFGI_W  = 2;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_WR_STATE = 2'd0,
    OP_WR_SUCC  = 2'd1,
    OP_QUERY    = 2'd2,
    OP_COMMIT   = 2'd3
  } op_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ACTION  = 3'd0,
    KIND_REGION  = 3'd1,
    KIND_NOSUCC  = 3'd2,
    KIND_COMMIT  = 3'd3,
    KIND_WAITING = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFGI_W-1:0] {
    CFG_SENSORS = 2'd0,
    CFG_ACTIONS = 2'd1,
    CFG_CUSTOMS = 2'd2,
    CFG_REGIONS = 2'd3
  } cfg_idx_t;

  // table write request, raised on a write transfer
  typedef struct packed {
    logic              prop_we;
    logic              succ_we;
    logic [ID_W-1:0]   idx;
    logic [VEC_W-1:0]  prop;
    logic [CNT_W-1:0]  cnt;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   succ_id;
  } sas_wr_t;

  // table read addresses; the read data is registered and returns in the next cycle
  typedef struct packed {
    logic [ID_W-1:0]  prop_id;
    logic [ID_W-1:0]  cur_id;
    logic [CNT_W-1:0] slot;
  } sas_rd_t;

  // configuration after capping to the supported ranges
  typedef struct packed {
    logic [CNT_W-1:0] ns;
    logic [CNT_W-1:0] na;
    logic [3:0]       rb;
  } sas_cfg_t;

endpackage

// ===== hw/rtl/strategy_automaton_stepper.sv =====
// ----------------------------------------------------------------------------
// strategy_automaton_stepper: controller automaton stepper
// Holds the configuration registers and ties the sequencer to the tables.
// ----------------------------------------------------------------------------
// Writes and commits: table writes give no result; a commit result is loaded
//   from S_CMT once the result register is free.
// Query: S_HEAD and S_HEAD2 read the current entry; S_SCAN, S_SUCC and S_CMP try each
//   successor in turn; S_ACT walks one action bit per cycle, holding while the result
//   register is full; S_REG gives the region result. One item is taken at a time.
// Reset: synchronous active-low rst_n clears the registers, current state and
//   pending flag; the tables stay undefined until written, with no clearing pass.
module strategy_automaton_stepper import sas_pkg::*; #(
  parameter int NUM_STATES      = 256,
  parameter int MAX_SUCCESSORS  = 16,
  parameter int MAX_SENSORS     = 16,
  parameter int MAX_ACTIONS     = 16,
  parameter int MAX_REGION_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFGI_W-1:0] cfg_index,
  input  logic [CFGD_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_state_index,
  input  logic [55:0]       in_proposition_bits,
  input  logic [4:0]        in_successor_count,
  input  logic [3:0]        in_successor_slot,
  input  logic [7:0]        in_successor_id,
  input  logic [15:0]       in_sensor_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [3:0]        out_action_index,
  output logic              out_action_value,
  output logic [7:0]        out_region_number,
  output logic              out_region_changed,
  output logic [7:0]        out_state_number,
  output logic              out_last
);

  localparam int SENS_CAP = (MAX_SENSORS < 16) ? MAX_SENSORS : 16;
  localparam int ACT_CAP  = (MAX_ACTIONS < 16) ? MAX_ACTIONS : 16;
  localparam int RGN_CAP  = (MAX_REGION_BITS < 8) ? MAX_REGION_BITS : 8;

  logic [CNT_W-1:0] sensor_count_r;
  logic [CNT_W-1:0] action_count_r;
  logic [3:0]       region_bits_r;

  sas_cfg_t         cfg;
  sas_wr_t          wr;
  sas_rd_t          rd;
  logic [VEC_W-1:0] prop_rd_data;
  logic [CNT_W-1:0] cnt_rd_data;
  logic [ID_W-1:0]  succ_rd_data;

  // configuration writes; custom count is accepted and not used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_count_r <= '0;
      action_count_r <= '0;
      region_bits_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SENSORS: sensor_count_r <= cfg_wdata;
        CFG_ACTIONS: action_count_r <= cfg_wdata;
        CFG_CUSTOMS: ;
        CFG_REGIONS: region_bits_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // cap the counts to the supported ranges
  always_comb begin
    cfg.ns = (32'(sensor_count_r) > SENS_CAP) ? CNT_W'(SENS_CAP) : sensor_count_r;
    cfg.na = (32'(action_count_r) > ACT_CAP) ? CNT_W'(ACT_CAP) : action_count_r;
    cfg.rb = (32'(region_bits_r) > RGN_CAP) ? 4'(RGN_CAP) : region_bits_r;
  end

  sas_seq #(
    .NUM_STATES (NUM_STATES)
  ) u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_state_index      (in_state_index),
    .in_proposition_bits (in_proposition_bits),
    .in_successor_count  (in_successor_count),
    .in_successor_slot   (in_successor_slot),
    .in_successor_id     (in_successor_id),
    .in_sensor_bits      (in_sensor_bits),
    .cfg                 (cfg),
    .wr                  (wr),
    .rd                  (rd),
    .prop_rd_data        (prop_rd_data),
    .cnt_rd_data         (cnt_rd_data),
    .succ_rd_data        (succ_rd_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_action_index    (out_action_index),
    .out_action_value    (out_action_value),
    .out_region_number   (out_region_number),
    .out_region_changed  (out_region_changed),
    .out_state_number    (out_state_number),
    .out_last            (out_last)
  );

  sas_store #(
    .NUM_STATES     (NUM_STATES),
    .MAX_SUCCESSORS (MAX_SUCCESSORS)
  ) u_store (
    .clk          (clk),
    .wr           (wr),
    .rd           (rd),
    .prop_rd_data (prop_rd_data),
    .cnt_rd_data  (cnt_rd_data),
    .succ_rd_data (succ_rd_data)
  );

endmodule

// ===== hw/rtl/sas_store.sv =====
// ----------------------------------------------------------------------------
// sas_store: automaton tables
// Proposition vectors, successor counts and successor lists, each a memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sas_store import sas_pkg::*; #(
  parameter int NUM_STATES     = 256,
  parameter int MAX_SUCCESSORS = 16
) (
  input  logic             clk,
  input  sas_wr_t          wr,
  input  sas_rd_t          rd,
  output logic [VEC_W-1:0] prop_rd_data,
  output logic [CNT_W-1:0] cnt_rd_data,
  output logic [ID_W-1:0]  succ_rd_data
);

  localparam int SW  = $clog2(NUM_STATES);
  localparam int SLW = (MAX_SUCCESSORS > 1) ? $clog2(MAX_SUCCESSORS) : 1;
  localparam int SUCC_DEPTH = NUM_STATES * (2 ** SLW);

  logic [VEC_W-1:0] prop_mem [NUM_STATES];
  logic [CNT_W-1:0] cnt_mem  [NUM_STATES];
  logic [ID_W-1:0]  succ_mem [SUCC_DEPTH];

  logic [VEC_W-1:0] prop_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;
  logic [ID_W-1:0]  succ_rd_r;

  logic             idx_ok;
  logic             slot_ok;
  logic [CNT_W-1:0] cnt_sat;

  // drop writes outside the tables, saturate the successor count
  assign idx_ok  = 32'(wr.idx) < NUM_STATES;
  assign slot_ok = 32'(wr.slot) < MAX_SUCCESSORS;
  assign cnt_sat = (32'(wr.cnt) > MAX_SUCCESSORS) ? CNT_W'(MAX_SUCCESSORS) : wr.cnt;

  // write ports
  always_ff @(posedge clk) begin
    if (wr.prop_we && idx_ok) begin
      prop_mem[SW'(wr.idx)] <= wr.prop;
      cnt_mem[SW'(wr.idx)]  <= cnt_sat;
    end
    if (wr.succ_we && idx_ok && slot_ok) begin
      succ_mem[{SW'(wr.idx), SLW'(wr.slot)}] <= wr.succ_id;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    prop_rd_r <= prop_mem[SW'(rd.prop_id)];
    cnt_rd_r  <= cnt_mem[SW'(rd.cur_id)];
    succ_rd_r <= succ_mem[{SW'(rd.cur_id), SLW'(rd.slot)}];
  end

  assign prop_rd_data = prop_rd_r;
  assign cnt_rd_data  = cnt_rd_r;
  assign succ_rd_data = succ_rd_r;

endmodule

// ===== hw/rtl/sas_seq.sv =====
// ----------------------------------------------------------------------------
// sas_seq: transition sequencer
// Takes input transfers, scans successors one table read at a time, and drives
// the result register, walking action bits one per cycle while it has room.
// ----------------------------------------------------------------------------
module sas_seq import sas_pkg::*; #(
  parameter int NUM_STATES = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [ID_W-1:0]   in_state_index,
  input  logic [VEC_W-1:0]  in_proposition_bits,
  input  logic [CNT_W-1:0]  in_successor_count,
  input  logic [SLOT_W-1:0] in_successor_slot,
  input  logic [ID_W-1:0]   in_successor_id,
  input  logic [SENS_W-1:0] in_sensor_bits,
  input  sas_cfg_t          cfg,
  output sas_wr_t           wr,
  output sas_rd_t           rd,
  input  logic [VEC_W-1:0]  prop_rd_data,
  input  logic [CNT_W-1:0]  cnt_rd_data,
  input  logic [ID_W-1:0]   succ_rd_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [3:0]        out_action_index,
  output logic              out_action_value,
  output logic [7:0]        out_region_number,
  output logic              out_region_changed,
  output logic [7:0]        out_state_number,
  output logic              out_last
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_HEAD   = 10'b0000000010,
    S_HEAD2  = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_SUCC   = 10'b0000010000,
    S_CMP    = 10'b0000100000,
    S_ACT    = 10'b0001000000,
    S_REG    = 10'b0010000000,
    S_NOSUCC = 10'b0100000000,
    S_CMT    = 10'b1000000000
  } state_t;

  // region number from the top rb bits of a vector
  function automatic logic [7:0] region_of(input logic [VEC_W-1:0] v, input logic [3:0] rb);
    logic [VEC_W-1:0] sh;
    begin
      sh = v >> (7'(VEC_W) - 7'(rb));
      region_of = sh[7:0] & 8'((9'd1 << rb) - 9'd1);
    end
  endfunction

  state_t            state_r, state_nxt;
  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [ID_W-1:0]   pend_r, pend_nxt;
  logic [SENS_W-1:0] want_r, want_nxt;
  logic [VEC_W-1:0]  cv_r, cv_nxt;
  logic [VEC_W-1:0]  nv_r, nv_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic [ID_W-1:0]   cand_r, cand_nxt;
  logic [CNT_W-1:0]  a_r, a_nxt;

  logic              out_valid_r, out_valid_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [3:0]        out_ai_r, out_ai_nxt;
  logic              out_av_r, out_av_nxt;
  logic [7:0]        out_rn_r, out_rn_nxt;
  logic              out_rc_r, out_rc_nxt;
  logic [7:0]        out_sn_r, out_sn_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              out_free;
  logic [SENS_W-1:0] smask;
  logic [5:0]        act_pos;
  logic              act_diff;
  logic              succ_ok;
  logic [7:0]        cur_region;
  logic [7:0]        nxt_region;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign smask    = SENS_W'((17'd1 << cfg.ns) - 17'd1);
  assign act_pos  = 6'(cfg.ns) + 6'(a_r);
  assign act_diff = cv_r[act_pos] ^ nv_r[act_pos];
  assign succ_ok  = 32'(succ_rd_data) < NUM_STATES;
  assign cur_region = region_of(cv_r, cfg.rb);
  assign nxt_region = region_of(nv_r, cfg.rb);

  // table writes go straight through on a write transfer
  always_comb begin
    wr.prop_we = accept && (op_t'(in_operation) == OP_WR_STATE);
    wr.succ_we = accept && (op_t'(in_operation) == OP_WR_SUCC);
    wr.idx     = in_state_index;
    wr.prop    = in_proposition_bits;
    wr.cnt     = in_successor_count;
    wr.slot    = in_successor_slot;
    wr.succ_id = in_successor_id;
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    want_nxt       = want_r;
    cv_nxt         = cv_r;
    nv_nxt         = nv_r;
    cnt_nxt        = cnt_r;
    i_nxt          = i_r;
    cand_nxt       = cand_r;
    a_nxt          = a_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_kind_nxt   = out_kind_r;
    out_ai_nxt     = out_ai_r;
    out_av_nxt     = out_av_r;
    out_rn_nxt     = out_rn_r;
    out_rc_nxt     = out_rc_r;
    out_sn_nxt     = out_sn_r;
    out_last_nxt   = out_last_r;
    rd.prop_id     = cur_r;
    rd.cur_id      = cur_r;
    rd.slot        = i_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_WR_STATE, OP_WR_SUCC: state_nxt = S_IDLE;
            OP_QUERY: begin
              want_nxt  = in_sensor_bits & smask;
              state_nxt = S_HEAD;
            end
            OP_COMMIT: state_nxt = S_CMT;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      // current vector and count are being read
      S_HEAD: state_nxt = S_HEAD2;
      S_HEAD2: begin
        cv_nxt    = prop_rd_data;
        cnt_nxt   = cnt_rd_data;
        i_nxt     = '0;
        state_nxt = S_SCAN;
      end
      // successor slot i is being read
      S_SCAN: begin
        if (i_r >= cnt_r) begin
          pend_valid_nxt = 1'b0;
          state_nxt      = S_NOSUCC;
        end else begin
          state_nxt = S_SUCC;
        end
      end
      // fetch the candidate vector, skip ids outside the tables
      S_SUCC: begin
        rd.prop_id = succ_rd_data;
        if (succ_ok) begin
          cand_nxt  = succ_rd_data;
          state_nxt = S_CMP;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_CMP: begin
        if ((prop_rd_data[SENS_W-1:0] & smask) == want_r) begin
          nv_nxt         = prop_rd_data;
          pend_valid_nxt = 1'b1;
          pend_nxt       = cand_r;
          a_nxt          = '0;
          state_nxt      = S_ACT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      // one action bit per cycle, hold while the result register is full
      S_ACT: begin
        if (a_r >= cfg.na) begin
          state_nxt = S_REG;
        end else if (!act_diff) begin
          a_nxt = a_r + 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACTION;
          out_ai_nxt    = 4'(a_r);
          out_av_nxt    = nv_r[act_pos];
          out_rn_nxt    = '0;
          out_rc_nxt    = 1'b0;
          out_sn_nxt    = cand_r;
          out_last_nxt  = 1'b0;
          a_nxt         = a_r + 1'b1;
        end
      end
      S_REG: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_REGION;
          out_ai_nxt    = '0;
          out_av_nxt    = 1'b0;
          out_rn_nxt    = nxt_region;
          out_rc_nxt    = (cur_region != nxt_region);
          out_sn_nxt    = cand_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_NOSUCC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_NOSUCC;
          out_ai_nxt    = '0;
          out_av_nxt    = 1'b0;
          out_rn_nxt    = '0;
          out_rc_nxt    = 1'b0;
          out_sn_nxt    = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      // adopt the pending state, or report waiting
      S_CMT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ai_nxt    = '0;
          out_av_nxt    = 1'b0;
          out_rn_nxt    = '0;
          out_rc_nxt    = 1'b0;
          out_last_nxt  = 1'b1;
          if (pend_valid_r) begin
            cur_nxt      = pend_r;
            out_kind_nxt = KIND_COMMIT;
            out_sn_nxt   = pend_r;
          end else begin
            out_kind_nxt = KIND_WAITING;
            out_sn_nxt   = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    want_r     <= want_nxt;
    cv_r       <= cv_nxt;
    nv_r       <= nv_nxt;
    cnt_r      <= cnt_nxt;
    i_r        <= i_nxt;
    cand_r     <= cand_nxt;
    a_r        <= a_nxt;
    out_kind_r <= out_kind_nxt;
    out_ai_r   <= out_ai_nxt;
    out_av_r   <= out_av_nxt;
    out_rn_r   <= out_rn_nxt;
    out_rc_r   <= out_rc_nxt;
    out_sn_r   <= out_sn_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_action_index   = out_ai_r;
  assign out_action_value   = out_av_r;
  assign out_region_number  = out_rn_r;
  assign out_region_changed = out_rc_r;
  assign out_state_number   = out_sn_r;
  assign out_last           = out_last_r;

  // a query transfer starts the table read sequence
  a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (op_t'(in_operation) == OP_QUERY) |=> state_r == S_HEAD)
    else $error("query did not start the table read");

  // a held commit result always names the current state
  a_commit_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_kind_r == KIND_COMMIT) |-> out_sn_r == cur_r)
    else $error("commit result differs from current state");

  // action walk only runs after a match was recorded
  a_act_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT) |-> pend_valid_r && (pend_r == cand_r))
    else $error("action walk without a pending state");

  // action counter never passes the action count
  a_act_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACT) |-> a_r <= cfg.na)
    else $error("action counter overran");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for strategy_automaton_stepper
// Loads a small set of automaton states, then steps the automaton with
// transition queries and commits under several register settings. Every
// transfer on the input side updates a local copy of the tables and the
// current state, which predicts the result transfers checked on the output.
// ----------------------------------------------------------------------------
module tb_top;
  import sas_pkg::*;

  localparam int NW            = 6;       // states kept fully loaded
  localparam int SETTLE_CYCLES = 80;      // longer than the slowest query
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 36;
  localparam int HOLD_AT_ITEM  = 120;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    op_t         op;
    logic [7:0]  idx;
    logic [55:0] prop;
    logic [4:0]  cnt;
    logic [3:0]  slot;
    logic [7:0]  sid;
    logic [15:0] sens;
  } step_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  act_idx;
    logic        act_val;
    logic [7:0]  region;
    logic        region_chg;
    logic [7:0]  state;
    logic        last;
  } step_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFGD_W-1:0] cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_kind;
  logic [3:0]        out_action_index;
  logic              out_action_value;
  logic [7:0]        out_region_number;
  logic              out_region_changed;
  logic [7:0]        out_state_number;
  logic              out_last;
  step_item_t        cur_item = '0;

  strategy_automaton_stepper i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (cur_item.op),
    .in_state_index      (cur_item.idx),
    .in_proposition_bits (cur_item.prop),
    .in_successor_count  (cur_item.cnt),
    .in_successor_slot   (cur_item.slot),
    .in_successor_id     (cur_item.sid),
    .in_sensor_bits      (cur_item.sens),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_action_index    (out_action_index),
    .out_action_value    (out_action_value),
    .out_region_number   (out_region_number),
    .out_region_changed  (out_region_changed),
    .out_state_number    (out_state_number),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Automaton copy: tables, current and pending state, register values
  // --------------------------------------------------------------------------
  logic [55:0] prop_mem [256];
  logic [4:0]  succ_cnt_mem [256];
  logic [7:0]  succ_mem [256][16];
  logic [7:0]  auto_state = '0;
  logic        pend_ok = 1'b0;
  logic [7:0]  pend_state = '0;
  logic [4:0]  cfg_ns = '0, cfg_na = '0, cfg_nc = '0;
  logic [3:0]  cfg_rb = '0;

  step_item_t   item_backlog [$];
  step_result_t due_results [$];
  int           fail_count = 0;
  int           items_taken = 0;
  int           cycle_count = 0;

  function automatic logic [7:0] region_of(logic [55:0] vec);
    int rb;
    logic [55:0] mask;
    rb = (cfg_rb > 8) ? 8 : int'(cfg_rb);
    if (rb == 0) return 8'd0;
    mask = (56'd1 << rb) - 56'd1;
    return 8'((vec >> (56 - rb)) & mask);
  endfunction

  // Apply one transfer to the automaton copy and queue the results it causes
  task automatic advance_automaton(step_item_t it);
    int           ns, na, cnt, i, pos;
    logic [15:0]  smask, want;
    logic [7:0]   s, nxt;
    logic         found;
    logic [55:0]  cv, nv;
    step_result_t r;
    ns = (cfg_ns > 16) ? 16 : int'(cfg_ns);
    na = (cfg_na > 16) ? 16 : int'(cfg_na);
    r = '0;
    r.last = 1'b1;
    case (it.op)
      OP_WR_STATE: begin
        prop_mem[it.idx]     = it.prop;
        succ_cnt_mem[it.idx] = (it.cnt > 5'd16) ? 5'd16 : it.cnt;
      end
      OP_WR_SUCC: begin
        succ_mem[it.idx][it.slot] = it.sid;
      end
      OP_COMMIT: begin
        if (pend_ok) begin
          auto_state = pend_state;
          r.kind     = KIND_COMMIT;
          r.state    = auto_state;
        end else begin
          r.kind = KIND_WAITING;
        end
        due_results = {due_results, r};
      end
      default: begin
        // scan successors in order, first sensor match wins
        smask = (ns == 0) ? 16'd0 : 16'((32'd1 << ns) - 32'd1);
        want  = it.sens & smask;
        cnt   = succ_cnt_mem[auto_state];
        found = 1'b0;
        nxt   = '0;
        for (i = 0; i < cnt && !found; i++) begin
          s = succ_mem[auto_state][i];
          if ((prop_mem[s][15:0] & smask) == want) begin
            found = 1'b1;
            nxt   = s;
          end
        end
        if (!found) begin
          pend_ok = 1'b0;
          r.kind  = KIND_NOSUCC;
          due_results = {due_results, r};
        end else begin
          pend_ok    = 1'b1;
          pend_state = nxt;
          cv = prop_mem[auto_state];
          nv = prop_mem[nxt];
          // one result per action bit that flips
          for (i = 0; i < na; i++) begin
            pos = ns + i;
            if (pos < 56 && cv[pos] != nv[pos]) begin
              r         = '0;
              r.kind    = KIND_ACTION;
              r.act_idx = 4'(i);
              r.act_val = nv[pos];
              r.state   = nxt;
              due_results = {due_results, r};
            end
          end
          r            = '0;
          r.kind       = KIND_REGION;
          r.region     = region_of(nv);
          r.region_chg = (region_of(cv) != region_of(nv));
          r.state      = nxt;
          r.last       = 1'b1;
          due_results = {due_results, r};
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Input driver: bursts of transfers with random gaps
  // --------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : item_driver
    step_item_t nxt_item;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_automaton(cur_item);
        items_taken <= items_taken + 1;
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (item_backlog.size() > 0) begin
        nxt_item = item_backlog.pop_front();
        cur_item <= nxt_item;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stall: random modes, plus one long hold to back up the block
  // --------------------------------------------------------------------------
  int  stall_mode = 0;
  int  mode_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : stall_pattern
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest due result
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 30)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    step_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 30)
          $display("%0t ns: result with none due, expected nothing, got kind %0d state %0d",
                   $time, out_kind, out_state_number);
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("action_index", want.act_idx, out_action_index);
        check_field("action_value", want.act_val, out_action_value);
        check_field("region_number", want.region, out_region_number);
        check_field("region_changed", want.region_chg, out_region_changed);
        check_field("state_number", want.state, out_state_number);
        check_field("last", want.last, out_last);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin : run_limit
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: only loaded states are ever reachable from the current state
  // --------------------------------------------------------------------------
  logic [7:0]  work_ids [NW];
  bit          working [256];
  logic [55:0] gen_prop [256];
  logic [4:0]  gen_cnt [256];
  bit          gen_slot_ok [256][16];

  function automatic logic [55:0] rand56();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[55:0];
  endfunction

  function automatic step_item_t random_fields(op_t op);
    step_item_t it;
    it.op   = op;
    it.idx  = 8'($urandom);
    it.prop = rand56();
    it.cnt  = 5'($urandom);
    it.slot = 4'($urandom);
    it.sid  = 8'($urandom);
    it.sens = 16'($urandom);
    return it;
  endfunction

  // leading successor slots that point at loaded states
  function automatic int safe_prefix(logic [7:0] s);
    int p;
    p = 0;
    while (p < 16 && gen_slot_ok[s][p]) p++;
    return p;
  endfunction

  function automatic logic [7:0] pick_idle_state();
    logic [7:0] s;
    do s = 8'($urandom); while (working[s]);
    return s;
  endfunction

  function automatic logic [7:0] pick_working();
    return work_ids[$urandom_range(0, NW - 1)];
  endfunction

  task automatic emit(step_item_t it);
    if (it.op == OP_WR_STATE) begin
      gen_prop[it.idx] = it.prop;
      gen_cnt[it.idx]  = it.cnt;
    end else if (it.op == OP_WR_SUCC) begin
      gen_slot_ok[it.idx][it.slot] = working[it.sid];
    end
    item_backlog = {item_backlog, it};
  endtask

  task automatic gen_random_item();
    int          r, p;
    logic [7:0]  s;
    step_item_t  it;
    r = $urandom_range(0, 99);
    if (r < 14) begin
      // state write: count within the loaded slot prefix, or above 16 if full
      it = random_fields(OP_WR_STATE);
      if ($urandom_range(0, 4) != 0) begin
        it.idx = ($urandom_range(0, 1) == 0) ? work_ids[NW-1] : pick_working();
        p = safe_prefix(it.idx);
        if (p == 16 && $urandom_range(0, 2) == 0) it.cnt = 5'($urandom_range(17, 31));
        else if ($urandom_range(0, 3) == 0)       it.cnt = 5'($urandom_range(0, p));
        else                                      it.cnt = 5'(p);
      end else begin
        it.idx = pick_idle_state();
      end
      emit(it);
    end else if (r < 34) begin
      // successor write: slots in use always point at loaded states
      it = random_fields(OP_WR_SUCC);
      if ($urandom_range(0, 4) != 0) begin
        s = ($urandom_range(0, 1) == 0) ? work_ids[NW-1] : pick_working();
        it.idx = s;
        p = safe_prefix(s);
        if (p < 16 && $urandom_range(0, 1) == 0) begin
          it.slot = 4'(p);
          it.sid  = pick_working();
        end else if (it.slot < gen_cnt[s]) begin
          it.sid = pick_working();
        end
      end else begin
        it.idx = pick_idle_state();
      end
      emit(it);
    end else if (r < 75) begin
      it = random_fields(OP_QUERY);
      if ($urandom_range(0, 9) < 7) begin
        it.sens = gen_prop[pick_working()][15:0];
        if ($urandom_range(0, 4) == 0) it.sens ^= 16'(1 << $urandom_range(0, 15));
      end
      emit(it);
      if ($urandom_range(0, 1) == 0) emit(random_fields(OP_COMMIT));
    end else begin
      emit(random_fields(OP_COMMIT));
    end
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [4:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_SENSORS: cfg_ns = val;
      CFG_ACTIONS: cfg_na = val;
      CFG_CUSTOMS: cfg_nc = val;
      default:     cfg_rb = val[3:0];
    endcase
  endtask

  task automatic set_config(logic [4:0] ns, logic [4:0] na, logic [4:0] nc, logic [4:0] rb);
    cfg_write(CFG_SENSORS, ns);
    cfg_write(CFG_ACTIONS, na);
    cfg_write(CFG_CUSTOMS, nc);
    cfg_write(CFG_REGIONS, rb);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for every item and result, then let trailing writes settle;
  // sample between edges so the driver's updates have landed
  task automatic wait_idle();
    @(negedge clk);
    while (item_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic directed_items();
    int          k, j;
    step_item_t  it;
    // commit before any query: waiting
    emit(random_fields(OP_COMMIT));
    // load a ring of states, two successors each
    for (k = 0; k < NW; k++) begin
      it      = random_fields(OP_WR_STATE);
      it.idx  = work_ids[k];
      it.prop = (k == 0) ? '0 : (k == 1) ? '1 : rand56();
      it.cnt  = 5'd2;
      emit(it);
      for (j = 0; j < 2; j++) begin
        it      = random_fields(OP_WR_SUCC);
        it.idx  = work_ids[k];
        it.slot = 4'(j);
        it.sid  = work_ids[(k + j + 1) % NW];
        emit(it);
      end
    end
    // all-zero to all-ones state: every action flips, region changes
    it      = random_fields(OP_QUERY);
    it.sens = 16'hFFFF;
    emit(it);
    // commit, then a repeated commit of the same state
    emit(random_fields(OP_COMMIT));
    emit(random_fields(OP_COMMIT));
    // sensors matching neither successor, then a commit with nothing pending
    it      = random_fields(OP_QUERY);
    it.sens = gen_prop[work_ids[2]][15:0] ^ 16'h1;
    if (it.sens == gen_prop[work_ids[3]][15:0]) it.sens ^= 16'h2;
    emit(it);
    emit(random_fields(OP_COMMIT));
  endtask

  initial begin : run_control
    int          ph, n, k;
    logic [7:0]  s;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // state 0 is current after reset; the rest of the set is random
    work_ids[0] = 8'd0;
    working[0]  = 1'b1;
    for (k = 1; k < NW; k++) begin
      do s = 8'($urandom_range(1, 255)); while (working[s]);
      work_ids[k] = s;
      working[s]  = 1'b1;
    end

    set_config(5'd16, 5'd16, 5'd16, 5'd8);
    directed_items();
    wait_idle();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config(5'd0, 5'd0, 5'd0, 5'd0);
        1:       set_config(5'd31, 5'd31, 5'd31, 5'd31);
        default: set_config(5'($urandom_range(0, 6)), 5'($urandom_range(0, 16)),
                            5'($urandom_range(0, 16)), 5'($urandom_range(0, 8)));
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) gen_random_item();
      wait_idle();
    end

    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
